@@ rtl/lz_backref_stream_decompressor_assert.svh @@
// ============================================================================
// lz_backref_stream_decompressor_assert.svh - assertion macros
// Shared clocked assertion forms for the decompressor checkers.
// ============================================================================
`ifndef LZ_BACKREF_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ_BACKREF_STREAM_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LZB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define LZB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/lzbsd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lzbsd_pkg - shared definitions
// Command format between front and back, stream constants and tag table.
// ============================================================================
package lzbsd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int OUT_LANES_DEF   = 8;
    localparam int OFF_W           = 12;
    localparam int LEN_W           = 9;
    localparam int CNT_W           = 4;
    localparam int QDEPTH          = 4;

    localparam logic [4:0] PH_GROUP = 5'd16;
    localparam logic [4:0] PH_REF2  = 5'd17;
    localparam logic [4:0] PH_REF3  = 5'd18;
    localparam logic [4:0] PH_SIZE_END = 5'd8;
    localparam logic [4:0] PH_TAG_END  = 5'd4;

    localparam logic [7:0] LIT_FLAG_MASK = 8'h80;
    localparam logic [8:0] LONG_BIAS     = 9'h012;
    localparam logic [8:0] SHORT_BIAS    = 9'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_REF   = 2'd2;

    localparam logic [1:0] K_STATUS = 2'd0;
    localparam logic [1:0] K_LIT    = 2'd1;
    localparam logic [1:0] K_COPY   = 2'd2;

    typedef struct packed {
        logic             clr;
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [OFF_W-1:0] off_m1;
        logic [LEN_W-1:0] len;
        logic             done;
        logic [1:0]       err;
    } cmd_t;

    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h59;
            2'd1:    r = 8'h61;
            2'd2:    r = 8'h7A;
            default: r = 8'h30;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/lzbsd_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lzbsd_front - stream parser
// Checks the header, walks flag groups and turns each byte into a command.
// ============================================================================
module lzbsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_new,
    output logic              in_ready,
    output logic              cmd_valid,
    output lzbsd_pkg::cmd_t   cmd,
    input  logic              cmd_ready
);

    logic [4:0]  phase_reg, phase_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  left_reg, left_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] prod_reg, prod_next;
    logic [15:0] pair_reg, pair_next;
    logic [1:0]  err_reg, err_next;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb begin
        logic                        want_copy;
        logic [lzbsd_pkg::LEN_W-1:0] clen;
        logic [12:0]                 off;
        logic [31:0]                 room;
        phase_next = phase_reg;
        flag_next  = flag_reg;
        left_next  = left_reg;
        size_next  = size_reg;
        prod_next  = prod_reg;
        pair_next  = pair_reg;
        err_next   = err_reg;
        if (in_new) begin
            phase_next = '0;
            flag_next  = '0;
            left_next  = '0;
            size_next  = '0;
            prod_next  = '0;
            pair_next  = '0;
            err_next   = lzbsd_pkg::ERR_NONE;
        end
        want_copy = 1'b0;
        clen      = '0;
        off       = '0;
        room      = '0;
        cmd       = '0;
        cmd.clr   = in_new;
        cmd.kind  = lzbsd_pkg::K_STATUS;
        cmd.data  = in_byte;
        if (phase_next < lzbsd_pkg::PH_GROUP) begin
            if (err_next == lzbsd_pkg::ERR_NONE) begin
                if (phase_next < lzbsd_pkg::PH_TAG_END) begin
                    if (in_byte != lzbsd_pkg::tag_byte(phase_next[1:0])) begin
                        err_next = lzbsd_pkg::ERR_MAGIC;
                    end
                end else if (phase_next < lzbsd_pkg::PH_SIZE_END) begin
                    size_next = {size_next[23:0], in_byte};
                end
                if (err_next == lzbsd_pkg::ERR_NONE) begin
                    phase_next = phase_next + 5'd1;
                end
            end
        end else if (err_next == lzbsd_pkg::ERR_NONE && prod_next < size_next) begin
            if (phase_next == lzbsd_pkg::PH_REF2) begin
                pair_next = {pair_next[15:8], in_byte};
                if (pair_next[15:12] != 4'd0) begin
                    want_copy = 1'b1;
                    clen = {5'd0, pair_next[15:12]} + lzbsd_pkg::SHORT_BIAS;
                end else begin
                    phase_next = lzbsd_pkg::PH_REF3;
                end
            end else if (phase_next == lzbsd_pkg::PH_REF3) begin
                want_copy = 1'b1;
                clen = {1'b0, in_byte} + lzbsd_pkg::LONG_BIAS;
            end else begin
                phase_next = lzbsd_pkg::PH_GROUP;
                if (left_next == 4'd0) begin
                    flag_next = in_byte;
                    left_next = 4'd8;
                end else if ((flag_next & lzbsd_pkg::LIT_FLAG_MASK) != 8'd0) begin
                    cmd.kind  = lzbsd_pkg::K_LIT;
                    prod_next = prod_next + 32'd1;
                    flag_next = {flag_next[6:0], 1'b0};
                    left_next = left_next - 4'd1;
                end else begin
                    pair_next  = {in_byte, 8'd0};
                    phase_next = lzbsd_pkg::PH_REF2;
                end
            end
            if (want_copy) begin
                phase_next = lzbsd_pkg::PH_GROUP;
                flag_next  = {flag_next[6:0], 1'b0};
                if (left_next != 4'd0) begin
                    left_next = left_next - 4'd1;
                end
                off = {1'b0, pair_next[11:0]} + 13'd1;
                if ({19'd0, off} > prod_next) begin
                    err_next = lzbsd_pkg::ERR_REF;
                end else begin
                    room = size_next - prod_next;
                    if ({23'd0, clen} > room) begin
                        clen = room[lzbsd_pkg::LEN_W-1:0];
                    end
                    prod_next = prod_next + {23'd0, clen};
                    if (clen != '0) begin
                        cmd.kind = lzbsd_pkg::K_COPY;
                    end
                end
                cmd.off_m1 = pair_next[11:0];
                cmd.len    = clen;
            end
        end
        cmd.done = (phase_next >= lzbsd_pkg::PH_GROUP) && (prod_next >= size_next);
        cmd.err  = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            flag_reg  <= '0;
            left_reg  <= '0;
            size_reg  <= '0;
            prod_reg  <= '0;
            pair_reg  <= '0;
            err_reg   <= lzbsd_pkg::ERR_NONE;
        end else if (in_valid && cmd_ready) begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            left_reg  <= left_next;
            size_reg  <= size_next;
            prod_reg  <= prod_next;
            pair_reg  <= pair_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ rtl/lzbsd_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lzbsd_queue - command queue
// Small FIFO that decouples the parser from the copy engine.
// ============================================================================
module lzbsd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    input  lzbsd_pkg::cmd_t wr_cmd,
    output logic            wr_ready,
    output logic            rd_valid,
    output lzbsd_pkg::cmd_t rd_cmd,
    input  logic            rd_ready
);

    localparam int PW = $clog2(lzbsd_pkg::QDEPTH);

    lzbsd_pkg::cmd_t entry_reg [lzbsd_pkg::QDEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     fill_reg;
    logic            push, pop;

    assign wr_ready = (fill_reg != (PW+1)'(lzbsd_pkg::QDEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = entry_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/lzbsd_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lzbsd_back - copy engine
// Runs commands against the history window and packs bytes into result words.
// ============================================================================
module lzbsd_back #(
    parameter int WINDOW_SIZE = lzbsd_pkg::WINDOW_SIZE_DEF,
    parameter int OUT_LANES   = lzbsd_pkg::OUT_LANES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  lzbsd_pkg::cmd_t             cmd,
    output logic                        cmd_ready,
    output logic                        out_valid,
    output logic [63:0]                 out_bytes,
    output logic [lzbsd_pkg::CNT_W-1:0] out_count,
    output logic                        out_last,
    output logic                        out_done,
    output logic [1:0]                  out_err,
    input  logic                        out_ready
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    logic [7:0]                  mem [WINDOW_SIZE];
    logic [7:0]                  mem_q;
    logic [1:0]                  state_reg;
    lzbsd_pkg::cmd_t             cur_reg;
    logic [AW-1:0]               wp_reg;
    logic [lzbsd_pkg::LEN_W-1:0] rem_reg;
    logic [63:0]                 word_reg, word_next;
    logic [lzbsd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        ov_reg;
    logic [7:0]                  wr_data;
    logic                        is_status, is_last, emit, slot_free, step;
    logic [AW-1:0]               raddr;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign slot_free = !ov_reg || out_ready;
    assign is_status = (cur_reg.kind == lzbsd_pkg::K_STATUS);
    assign wr_data   = (cur_reg.kind == lzbsd_pkg::K_LIT) ? cur_reg.data : mem_q;
    assign is_last   = is_status || (rem_reg == lzbsd_pkg::LEN_W'(1));
    assign cnt_next  = is_status ? cnt_reg : cnt_reg + lzbsd_pkg::CNT_W'(1);
    assign emit      = is_last || (cnt_next == lzbsd_pkg::CNT_W'(OUT_LANES));
    assign step      = (state_reg == ST_WR) && (!emit || slot_free);
    assign raddr     = wp_reg - AW'(cur_reg.off_m1) - AW'(1);
    assign out_valid = ov_reg;

    always_comb begin
        word_next = word_reg;
        for (int i = 0; i < OUT_LANES; i++) begin
            if (!is_status && cnt_reg == lzbsd_pkg::CNT_W'(i)) begin
                word_next[8*i +: 8] = wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            mem_q <= mem[raddr];
        end
        if (step && !is_status) begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            wp_reg    <= '0;
            rem_reg   <= '0;
            word_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            if (ov_reg && out_ready && !(step && emit)) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cur_reg <= cmd;
                        if (cmd.clr) begin
                            wp_reg <= '0;
                        end
                        unique case (cmd.kind)
                            lzbsd_pkg::K_COPY: begin
                                rem_reg   <= cmd.len;
                                state_reg <= ST_RD;
                            end
                            lzbsd_pkg::K_LIT: begin
                                rem_reg   <= lzbsd_pkg::LEN_W'(1);
                                state_reg <= ST_WR;
                            end
                            default: begin
                                rem_reg   <= '0;
                                state_reg <= ST_WR;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    state_reg <= ST_WR;
                end
                ST_WR: begin
                    if (step) begin
                        if (!is_status) begin
                            wp_reg  <= wp_reg + AW'(1);
                            rem_reg <= rem_reg - lzbsd_pkg::LEN_W'(1);
                        end
                        if (emit) begin
                            ov_reg    <= 1'b1;
                            out_bytes <= word_next;
                            out_count <= cnt_next;
                            out_last  <= is_last;
                            out_done  <= cur_reg.done;
                            out_err   <= cur_reg.err;
                            word_reg  <= '0;
                            cnt_reg   <= '0;
                        end else begin
                            word_reg <= word_next;
                            cnt_reg  <= cnt_next;
                        end
                        state_reg <= is_last ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lz_backref_stream_decompressor.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lz_backref_stream_decompressor - LZ back-reference stream decoder
// Header check, flag-group parsing and windowed copy with packed output.
//
// channel   dir  tdata                           tuser                  tlast
// s_axis    in   [7:0] in_byte                   [0] new_stream         -
// m_axis    out  [63:0] out_bytes [67:64] count  [0] done [2:1] error   run_last
//
// The parser turns each accepted byte into one command; header, flag and
// reference-prefix bytes give status commands. The copy engine handles a
// literal or status result in its write state, and a copy in its read and
// write states per byte, set by the registered read and the write of the
// history RAM. A held result stalls the engine; a 4-entry command queue lets the parser run ahead until it fills.
// Reset clears control state only; history is valid once written.
// ============================================================================
module lz_backref_stream_decompressor #(
    parameter int WINDOW_SIZE = lzbsd_pkg::WINDOW_SIZE_DEF,
    parameter int OUT_LANES   = lzbsd_pkg::OUT_LANES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] new_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] out_bytes, [67:64] byte_count
    output logic [2:0]  m_axis_tuser,   // [0] stream_done, [2:1] error_code
    output logic        m_axis_tlast    // run_last
);

    lzbsd_pkg::cmd_t             f_cmd, q_cmd;
    logic                        f_valid, f_ready, q_valid, q_ready;
    logic [63:0]                 o_bytes;
    logic [lzbsd_pkg::CNT_W-1:0] o_count;
    logic                        o_done;
    logic [1:0]                  o_err;

    lzbsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_new    (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    lzbsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_cmd   (f_cmd),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd),
        .rd_ready (q_ready)
    );

    lzbsd_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .OUT_LANES   (OUT_LANES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (q_ready),
        .out_valid (m_axis_tvalid),
        .out_bytes (o_bytes),
        .out_count (o_count),
        .out_last  (m_axis_tlast),
        .out_done  (o_done),
        .out_err   (o_err),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, o_count, o_bytes};
    assign m_axis_tuser = {o_err, o_done};

endmodule

@@ rtl/lzbsd_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lzbsd_checker - port-level assertions
// Watches the result channel of the decompressor and binds to the top level.
// ============================================================================
`include "lz_backref_stream_decompressor_assert.svh"

module lzbsd_checker #(
    parameter int OUT_LANES = lzbsd_pkg::OUT_LANES_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `LZB_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `LZB_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `LZB_ASSERT_NOW(a_full_mid, aclk, aresetn, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[67:64] == 4'(OUT_LANES))
    `LZB_ASSERT_NOW(a_err_empty, aclk, aresetn, m_axis_tvalid && m_axis_tuser[2:1] != 2'd0, m_axis_tdata[67:64] == 4'd0 && m_axis_tlast)

endmodule

bind lz_backref_stream_decompressor lzbsd_checker #(.OUT_LANES(OUT_LANES)) u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/lz_stream_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lz_stream_checker - decoded output checker
// Watches both stream channels, models the decoder state per accepted input
// byte and compares every output transaction against the predicted words.
// ============================================================================
module lz_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_words
);

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        done;
        logic [1:0]  err;
    } out_word_t;

    out_word_t   word_q[$];
    logic [7:0]  hist[lzbsd_pkg::WINDOW_SIZE_DEF];
    logic [11:0] wr_ptr;
    logic [31:0] produced, declared;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [4:0]  phase;
    logic [15:0] pair;
    logic [1:0]  err;
    logic [7:0]  run_bytes[$];
    int          fails = 0;

    assign fail_count = fails;

    function automatic logic [7:0] magic_byte(input logic [4:0] idx);
        case (idx)
            5'd0:    return 8'h59;
            5'd1:    return 8'h61;
            5'd2:    return 8'h7A;
            default: return 8'h30;
        endcase
    endfunction

    task automatic clear_state();
        wr_ptr = '0; produced = '0; declared = '0; flags = '0;
        flags_left = '0; phase = '0; pair = '0; err = lzbsd_pkg::ERR_NONE;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        hist[wr_ptr] = b;
        wr_ptr = wr_ptr + 12'd1;
        produced = produced + 32'd1;
        run_bytes.push_back(b);
    endtask

    task automatic shift_flag();
        flags = flags << 1;
        if (flags_left != 0) flags_left = flags_left - 4'd1;
    endtask

    task automatic replay_copy(input logic [31:0] len);
        logic [31:0] back_off;
        back_off = {20'd0, pair[11:0]} + 32'd1;
        phase = lzbsd_pkg::PH_GROUP;
        shift_flag();
        if (back_off > produced) begin
            err = lzbsd_pkg::ERR_REF;
            return;
        end
        if (len > declared - produced) len = declared - produced;
        for (int i = 0; i < len; i++) emit_byte(hist[wr_ptr - back_off[11:0]]);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fresh);
        out_word_t w;
        int        nres;
        logic      done;
        if (fresh) clear_state();
        run_bytes.delete();
        if (phase < lzbsd_pkg::PH_GROUP) begin
            if (err == lzbsd_pkg::ERR_NONE) begin
                if (phase < lzbsd_pkg::PH_TAG_END) begin
                    if (b != magic_byte(phase)) err = lzbsd_pkg::ERR_MAGIC;
                end else if (phase < lzbsd_pkg::PH_SIZE_END) begin
                    declared = {declared[23:0], b};
                end
                if (err == lzbsd_pkg::ERR_NONE) phase = phase + 5'd1;
            end
        end else if (err == lzbsd_pkg::ERR_NONE && produced < declared) begin
            if (phase == lzbsd_pkg::PH_REF2) begin
                pair[7:0] = b;
                if (pair[15:12] != 0) replay_copy(32'(pair[15:12]) + 32'd2);
                else phase = lzbsd_pkg::PH_REF3;
            end else if (phase == lzbsd_pkg::PH_REF3) begin
                replay_copy(32'(b) + 32'h12);
            end else begin
                phase = lzbsd_pkg::PH_GROUP;
                if (flags_left == 0) begin
                    flags = b;
                    flags_left = 4'd8;
                end else if ((flags & lzbsd_pkg::LIT_FLAG_MASK) != 0) begin
                    emit_byte(b);
                    shift_flag();
                end else begin
                    pair = {b, 8'h00};
                    phase = lzbsd_pkg::PH_REF2;
                end
            end
        end
        done = phase >= lzbsd_pkg::PH_GROUP && produced >= declared;
        nres = run_bytes.size() == 0 ? 1 : (run_bytes.size() + 7) / 8;
        for (int k = 0; k < nres; k++) begin
            w = '0;
            for (int i = 0; i < 8; i++) begin
                if (k * 8 + i < run_bytes.size()) begin
                    w.data[8*i +: 8] = run_bytes[k*8+i];
                    w.cnt = w.cnt + 4'd1;
                end
            end
            w.last = (k + 1 == nres);
            w.done = done;
            w.err  = err;
            word_q.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        out_word_t got, want;
        if (!aresetn) begin
            clear_state();
            word_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast,
                       m_axis_tuser[0], m_axis_tuser[2:1]};
                if (word_q.size() == 0) begin
                    $display("%0t: unexpected output transaction %h", $time, got);
                    fails++;
                end else begin
                    want = word_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected data=%h cnt=%0d last=%b done=%b err=%0d",
                                 $time, want.data, want.cnt, want.last, want.done, want.err);
                        $display("%0t:          actual   data=%h cnt=%0d last=%b done=%b err=%0d",
                                 $time, got.data, got.cnt, got.last, got.done, got.err);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tuser[0]);
        end
        pending_words = word_q.size();
    end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top - decompressor testbench
// Feeds well-formed compressed streams (literals, short and long overlapping
// references, truncation, zero size) plus bad tags, early references and
// noise, with bursty input and random output stalls.
// ============================================================================
module tb_top;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count, pending_words;
    int          idle_cycles = 0;
    logic [7:0]  stream_bytes[$];
    logic        stream_fresh[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lz_backref_stream_decompressor u_top (.*);

    lz_stream_checker u_chk (.*);

    // receiver: stall pattern changes mode every so often
    int stall_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ($urandom_range(0, 5) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push(input logic [7:0] b, input logic fresh = 1'b0);
        stream_bytes.push_back(b);
        stream_fresh.push_back(fresh);
    endtask

    task automatic push_header(input logic [31:0] size, input logic bad_tag = 1'b0);
        push(8'h59, 1'b1);
        push(bad_tag ? 8'h58 : 8'h61);
        push(8'h7A);
        push(8'h30);
        for (int i = 3; i >= 0; i--) push(size[8*i +: 8]);
        for (int i = 0; i < 8; i++) push(8'($urandom));
    endtask

    // a random stream body: groups with literals and references within history, or with allow_early sometimes beyond it
    task automatic push_body(input int items, input logic allow_early);
        int made = 0;
        logic [7:0] fl;
        int off, len;
        while (items > 0) begin
            fl = 8'($urandom);
            if (made == 0) fl[7] = 1'b1;
            push(fl);
            for (int i = 7; i >= 0 && items > 0; i--) begin
                items--;
                if (fl[i] || made == 0) begin
                    push(8'($urandom));
                    made++;
                end else begin
                    off = allow_early && $urandom_range(0, 9) == 0 ?
                          $urandom_range(made, 4095) : $urandom_range(0, made - 1);
                    if (made > 4096) off = $urandom_range(0, 4095);
                    if ($urandom_range(0, 1)) begin
                        len = $urandom_range(1, 15);
                        push({len[3:0], 4'(off >> 8)});
                        push(off[7:0]);
                        made += len + 2;
                    end else begin
                        len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 40);
                        push({4'h0, 4'(off >> 8)});
                        push(off[7:0]);
                        push(len[7:0]);
                        made += len + 18;
                    end
                end
            end
        end
    endtask

    initial begin
        int   gap, burst;
        logic fire;
        // directed: tag bytes, bad magic, zero size, early ref, unfinished long-ref prefix
        push_header(32'd0);
        push(8'hFF);
        push_header(32'h0000_0040, 1'b1);
        push(8'h00);
        push_header(32'h0000_0200);
        push(8'h7F); push(8'hA5); push(8'h0F); push(8'hFF); push(8'hFF);
        push_header(32'h0000_0020);
        push(8'h80); push(8'h00); push(8'h00); push(8'h10);
        // random: mostly well-formed streams
        while (stream_bytes.size() < 255) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_header($urandom, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 6)) push(8'($urandom));
                end
                1: repeat ($urandom_range(1, 5)) push(8'($urandom), 1'($urandom_range(0, 1)));
                default: begin
                    push_header($urandom_range(0, 3) == 0 ? $urandom_range(0, 60)
                                                          : $urandom_range(100, 2000));
                    push_body($urandom_range(4, 30), 1'b1);
                end
            endcase
        end
        // a byte that fills every tuser/tdata bit both ways is covered above
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (stream_bytes.size() > 0) begin
            burst = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
            while (burst > 0 && stream_bytes.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_bytes[0];
                s_axis_tuser  <= stream_fresh[0];
                @(negedge aclk);
                fire = s_axis_tready;
                @(posedge aclk);
                if (fire) begin
                    void'(stream_bytes.pop_front());
                    void'(stream_fresh.pop_front());
                    burst--;
                end
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
